### src/heightmap_triangle_height_query_top_defines.svh
// Assertion macros shared by the heightmap height query RTL.
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_TOP_DEFINES_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define HTHQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define HTHQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/hthq_pkg.sv
// Shared types, field layout and constants of the heightmap height query block.
`timescale 1ns / 1ps
`default_nettype none

package hthq_pkg;

    // Default configuration
    localparam int TILES_DEF     = 256;
    localparam int FRAC_BITS_DEF = 8;

    // Field widths
    localparam int VIDX_W  = 17;
    localparam int HBYTE_W = 8;
    localparam int POS_W   = 18;
    localparam int HQ_W    = 16;

    // Slave tdata layout, lowest field first
    localparam int VIDX_LSB  = 0;
    localparam int HBYTE_LSB = VIDX_LSB + VIDX_W;
    localparam int POSX_LSB  = HBYTE_LSB + HBYTE_W;
    localparam int POSZ_LSB  = POSX_LSB + POS_W;
    localparam int S_TDATA_W = ((POSZ_LSB + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = HQ_W;

    // Request kinds carried in tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Saturation level of the result
    localparam int HQ_MAX = (1 << HQ_W) - 1;

    // Result queue
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

    // Read sequencer phases of one query
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RD2,
        PH_RD3
    } t_phase;

    // One result item
    typedef struct packed {
        logic            is_land;
        logic [HQ_W-1:0] height_q8;
    } t_result;

endpackage

`default_nettype wire

### src/hthq_grid_ram.sv
// Single-port height grid memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hthq_grid_ram #(
    parameter int DEPTH  = (hthq_pkg::TILES_DEF + 1) * (hthq_pkg::TILES_DEF + 1),
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire                         i_clk,
    input  wire                         i_we,
    input  wire  [ADDR_W-1:0]           i_addr,
    input  wire  [hthq_pkg::HBYTE_W-1:0] i_wdata,
    output logic [hthq_pkg::HBYTE_W-1:0] o_rdata
);

    logic [hthq_pkg::HBYTE_W-1:0] r_mem [DEPTH];

    // Write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

### src/hthq_out_fifo.sv
// Small result queue between the interpolation pipe and the master port.
`timescale 1ns / 1ps
`default_nettype none

module hthq_out_fifo (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_push,
    input  hthq_pkg::t_result                  i_push_data,
    input  wire                                i_pop,
    output hthq_pkg::t_result                  o_head,
    output logic                               o_valid,
    output logic [hthq_pkg::OFIFO_CNT_W-1:0]   o_count
);

    hthq_pkg::t_result                  r_buf [hthq_pkg::OFIFO_DEPTH];
    logic [hthq_pkg::OFIFO_PTR_W-1:0]   r_wr_ptr;
    logic [hthq_pkg::OFIFO_PTR_W-1:0]   r_rd_ptr;
    logic [hthq_pkg::OFIFO_CNT_W-1:0]   r_count;
    logic                               w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_head  = r_buf[r_rd_ptr];
    assign o_count = r_count;

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### src/heightmap_triangle_height_query_top.sv
// Top level of the heightmap triangle height query block.
`timescale 1ns / 1ps
`default_nettype none

// Heightmap height query. A load item (tuser = 0) writes one raw height byte
// into the (TILES+1)^2 vertex grid; an index beyond the grid is dropped. A
// query item (tuser = 1) reads three grid vertices, one per cycle, from the
// single-port grid memory, so no further query or load is accepted until
// its third read has been issued. The products are registered, then summed
// and saturated and pushed into a four-entry result queue, from which the
// result reaches the master port. The slave port stalls while a query is
// reading and while in-flight and queued results fill that queue.
// The grid holds no reset value: a query must touch only written vertices.
// The result is the height in raw byte units with FRAC_BITS fraction bits,
// saturated to 16 bits; off-grid positions give is_land = 0, height 0.
module heightmap_triangle_height_query_top #(
    parameter int TILES     = hthq_pkg::TILES_DEF,
    parameter int FRAC_BITS = hthq_pkg::FRAC_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // slave item: vertex_index, height_byte, pos_x, pos_z (lowest bit up)
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire  [hthq_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // slave tuser: req_type
    input  wire  [0:0]                        i_s_axis_tuser,
    // master item: height_q8
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    output logic [hthq_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    // master tuser: is_land
    output logic [0:0]                        o_m_axis_tuser
);

    `include "heightmap_triangle_height_query_top_defines.svh"

    localparam int SIDE       = TILES + 1;
    localparam int GRID_DEPTH = SIDE * SIDE;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);
    localparam int XI_W       = $clog2(TILES);
    localparam int W_W        = FRAC_BITS + 1;
    localparam int PROD_W     = FRAC_BITS + 11;
    localparam int SUM_W      = (FRAC_BITS + 11 > 18) ? FRAC_BITS + 11 : 18;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int POS_LIMIT  = TILES * ONE;
    localparam int POS_W      = hthq_pkg::POS_W;
    localparam int HBYTE_W    = hthq_pkg::HBYTE_W;
    localparam int CNT_W      = hthq_pkg::OFIFO_CNT_W;

    localparam logic signed [SUM_W-1:0] HQ_MAX_S = SUM_W'(hthq_pkg::HQ_MAX);

    // Input fields
    logic                       w_req_type;
    logic [hthq_pkg::VIDX_W-1:0] w_vidx;
    logic [HBYTE_W-1:0]         w_hbyte;
    logic [POS_W-1:0]           w_pos_x;
    logic [POS_W-1:0]           w_pos_z;

    assign w_req_type = i_s_axis_tuser[0];
    assign w_vidx     = i_s_axis_tdata[hthq_pkg::VIDX_LSB +: hthq_pkg::VIDX_W];
    assign w_hbyte    = i_s_axis_tdata[hthq_pkg::HBYTE_LSB +: HBYTE_W];
    assign w_pos_x    = i_s_axis_tdata[hthq_pkg::POSX_LSB +: POS_W];
    assign w_pos_z    = i_s_axis_tdata[hthq_pkg::POSZ_LSB +: POS_W];

    // Query decode
    logic [31:0]        w_px_mag;
    logic [31:0]        w_pz_mag;
    logic [31:0]        w_xi32;
    logic [31:0]        w_zi32;
    logic [XI_W-1:0]    w_xi;
    logic [XI_W-1:0]    w_zi;
    logic [W_W-1:0]     w_fx;
    logic [W_W-1:0]     w_fz;
    logic [W_W-1:0]     w_fsum;
    logic               w_land;
    logic               w_upper;
    logic [W_W-1:0]     w_w1;
    logic [W_W-1:0]     w_w2;
    logic [ADDR_W-1:0]  w_base;
    logic               w_vidx_ok;

    assign w_px_mag = 32'(w_pos_x[POS_W-2:0]);
    assign w_pz_mag = 32'(w_pos_z[POS_W-2:0]);
    assign w_land   = !w_pos_x[POS_W-1] && !w_pos_z[POS_W-1]
                   && (w_px_mag < 32'(POS_LIMIT)) && (w_pz_mag < 32'(POS_LIMIT));
    assign w_xi32   = w_px_mag >> FRAC_BITS;
    assign w_zi32   = w_pz_mag >> FRAC_BITS;
    assign w_xi     = w_xi32[XI_W-1:0];
    assign w_zi     = w_zi32[XI_W-1:0];
    assign w_fx     = W_W'(w_pos_x[FRAC_BITS-1:0]);
    assign w_fz     = W_W'(w_pos_z[FRAC_BITS-1:0]);
    assign w_fsum   = w_fx + w_fz;
    assign w_upper  = (w_fsum >= W_W'(ONE));
    assign w_w1     = w_upper ? (W_W'(ONE) - w_fx) : w_fz;
    assign w_w2     = w_upper ? (W_W'(ONE) - w_fz) : w_fx;
    assign w_base   = w_land ? (ADDR_W'(w_zi) * ADDR_W'(SIDE) + ADDR_W'(w_xi)) : '0;
    assign w_vidx_ok = (32'(w_vidx) < 32'(GRID_DEPTH));

    // Sequencer and credit state
    hthq_pkg::t_phase   r_phase;
    hthq_pkg::t_phase   n_phase;
    logic [CNT_W-1:0]   r_inflight;
    logic [CNT_W-1:0]   w_fifo_count;
    logic               w_credit_ok;
    logic               w_s_acc;
    logic               w_q_acc;
    logic               w_l_acc;

    assign w_credit_ok = ((CNT_W+1)'(r_inflight) + (CNT_W+1)'(w_fifo_count))
                       < (CNT_W+1)'(hthq_pkg::OFIFO_DEPTH);
    assign w_s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_q_acc = w_s_acc && (w_req_type == hthq_pkg::REQ_QUERY);
    assign w_l_acc = w_s_acc && (w_req_type == hthq_pkg::REQ_LOAD);

    // Query context
    logic [ADDR_W-1:0]  r_base;
    logic [W_W-1:0]     r_w1;
    logic [W_W-1:0]     r_w2;
    logic               r_upper;
    logic               r_land;
    logic [HBYTE_W-1:0] r_h1;
    logic [HBYTE_W-1:0] r_h2;

    // Memory port
    logic               w_ram_we;
    logic [ADDR_W-1:0]  w_ram_addr;
    logic [HBYTE_W-1:0] w_ram_rdata;

    // Next phase
    always_comb begin
        case (r_phase)
            hthq_pkg::PH_IDLE: n_phase = w_q_acc ? hthq_pkg::PH_RD2 : hthq_pkg::PH_IDLE;
            hthq_pkg::PH_RD2:  n_phase = hthq_pkg::PH_RD3;
            hthq_pkg::PH_RD3:  n_phase = hthq_pkg::PH_IDLE;
            default:           n_phase = hthq_pkg::PH_IDLE;
        endcase
    end

    // Drive the memory port and the slave ready per phase
    always_comb begin
        case (r_phase)
            hthq_pkg::PH_IDLE: begin
                o_s_axis_tready = w_credit_ok;
                w_ram_we        = w_l_acc && w_vidx_ok;
                w_ram_addr      = w_l_acc ? ADDR_W'(w_vidx) : (w_base + ADDR_W'(SIDE));
            end
            hthq_pkg::PH_RD2: begin
                o_s_axis_tready = 1'b0;
                w_ram_we        = 1'b0;
                w_ram_addr      = r_base + ADDR_W'(1);
            end
            hthq_pkg::PH_RD3: begin
                o_s_axis_tready = 1'b0;
                w_ram_we        = 1'b0;
                w_ram_addr      = r_upper ? (r_base + ADDR_W'(SIDE + 1)) : r_base;
            end
            default: begin
                o_s_axis_tready = 1'b0;
                w_ram_we        = 1'b0;
                w_ram_addr      = r_base;
            end
        endcase
    end

    hthq_grid_ram #(
        .DEPTH  (GRID_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_hbyte),
        .o_rdata (w_ram_rdata)
    );

    // Hold query context and collect the first two vertex heights
    always_ff @(posedge i_clk) begin
        if (w_q_acc) begin
            r_base  <= w_base;
            r_w1    <= w_w1;
            r_w2    <= w_w2;
            r_upper <= w_upper;
            r_land  <= w_land;
        end
        if (r_phase == hthq_pkg::PH_RD2) begin
            r_h1 <= w_ram_rdata;
        end
        if (r_phase == hthq_pkg::PH_RD3) begin
            r_h2 <= w_ram_rdata;
        end
    end

    // Products of the height deltas and the barycentric weights
    logic                       r_c_vld;
    logic signed [HBYTE_W:0]    w_d1;
    logic signed [HBYTE_W:0]    w_d2;
    logic signed [W_W:0]        w_w1s;
    logic signed [W_W:0]        w_w2s;
    logic signed [PROD_W-1:0]   w_p1;
    logic signed [PROD_W-1:0]   w_p2;

    assign w_d1  = signed'({1'b0, r_h1}) - signed'({1'b0, w_ram_rdata});
    assign w_d2  = signed'({1'b0, r_h2}) - signed'({1'b0, w_ram_rdata});
    assign w_w1s = signed'({1'b0, r_w1});
    assign w_w2s = signed'({1'b0, r_w2});
    assign w_p1  = w_d1 * w_w1s;
    assign w_p2  = w_d2 * w_w2s;

    logic                       r_m_vld;
    logic                       r_m_land;
    logic [HBYTE_W-1:0]         r_hb;
    logic signed [PROD_W-1:0]   r_p1;
    logic signed [PROD_W-1:0]   r_p2;

    always_ff @(posedge i_clk) begin
        if (r_c_vld) begin
            r_hb     <= w_ram_rdata;
            r_p1     <= w_p1;
            r_p2     <= w_p2;
            r_m_land <= r_land;
        end
    end

    // Sum and saturate
    logic signed [SUM_W-1:0]    w_hb_s;
    logic signed [SUM_W-1:0]    w_sum;
    hthq_pkg::t_result          w_res;
    logic                       w_push;

    assign w_hb_s = signed'(SUM_W'({r_hb, {FRAC_BITS{1'b0}}}));
    assign w_sum  = w_hb_s + SUM_W'(r_p1) + SUM_W'(r_p2);
    assign w_push = r_m_vld;

    always_comb begin
        w_res.is_land = r_m_land;
        if (!r_m_land || (w_sum < 0)) begin
            w_res.height_q8 = '0;
        end else if (w_sum > HQ_MAX_S) begin
            w_res.height_q8 = hthq_pkg::HQ_W'(hthq_pkg::HQ_MAX);
        end else begin
            w_res.height_q8 = w_sum[hthq_pkg::HQ_W-1:0];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= hthq_pkg::PH_IDLE;
            r_c_vld    <= 1'b0;
            r_m_vld    <= 1'b0;
            r_inflight <= '0;
        end else begin
            r_phase <= n_phase;
            r_c_vld <= (r_phase == hthq_pkg::PH_RD3);
            r_m_vld <= r_c_vld;
            case ({w_q_acc, w_push})
                2'b10:   r_inflight <= r_inflight + 1'b1;
                2'b01:   r_inflight <= r_inflight - 1'b1;
                default: r_inflight <= r_inflight;
            endcase
        end
    end

    // Result queue toward the master port
    hthq_pkg::t_result  w_head;
    logic               w_pop;

    assign w_pop = o_m_axis_tvalid && i_m_axis_tready;

    hthq_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_res),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_valid     (o_m_axis_tvalid),
        .o_count     (w_fifo_count)
    );

    assign o_m_axis_tdata = w_head.height_q8;
    assign o_m_axis_tuser = w_head.is_land;

    // Checks
    `HTHQ_ASSERT(a_query_reads, i_clk, i_rst_n, w_q_acc |=> (r_phase == hthq_pkg::PH_RD2) ##1 (r_phase == hthq_pkg::PH_RD3), "query did not step through its reads")
    `HTHQ_ASSERT(a_query_result, i_clk, i_rst_n, w_q_acc |-> ##4 w_push, "query result not queued four cycles after accept")
    `HTHQ_ASSERT(a_no_overflow, i_clk, i_rst_n, ((CNT_W+1)'(r_inflight) + (CNT_W+1)'(w_fifo_count)) <= (CNT_W+1)'(hthq_pkg::OFIFO_DEPTH), "result queue overcommitted")
    `HTHQ_ASSERT_ALWAYS(a_reset_quiet, i_clk, $past(!i_rst_n) |-> !o_m_axis_tvalid, "result valid right after reset")

endmodule

`default_nettype wire

### sim/tb_heightmap_triangle_height_query_top.sv
// Testbench for the heightmap triangle height query block: grid loads, queries, handshakes.
`timescale 1ns / 1ps

module tb_heightmap_triangle_height_query_top;

    import hthq_pkg::*;

    localparam int TILES      = TILES_DEF;
    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int ONE        = 1 << FRAC;
    localparam int SIDE       = TILES + 1;
    localparam int CELLS      = SIDE * SIDE;
    localparam int RAND_ITEMS = 1550;
    localparam int LIMIT      = 1000000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   o_s_axis_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [0:0]             s_tuser;
    logic                   o_m_axis_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;
    logic [0:0]             o_m_axis_tuser;

    // Shadow of the height grid and which vertices hold a written value
    logic [7:0] grid_shadow [CELLS];
    bit         vertex_written [CELLS];
    int         ready_cells [$];

    t_result    pending_heights [$];
    t_result    next_height;
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         items_counted = 0;
    bit         tx_gaps = 1'b0;
    bit         rx_gaps = 1'b0;
    int         rx_hold_cycles = 0;
    int         rx_stall_left = 0;

    heightmap_triangle_height_query_top #(
        .TILES     (TILES),
        .FRAC_BITS (FRAC)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Expected result of a query against the shadow grid
    function automatic t_result predict_height(logic signed [POS_W-1:0] px,
                                               logic signed [POS_W-1:0] pz);
        t_result res;
        int x, z, xi, zi, fx, fz, h0, h1, h2, h3, acc;
        res = '0;
        x = px;
        z = pz;
        if (x < 0 || z < 0 || x >= TILES * ONE || z >= TILES * ONE)
            return res;
        xi = x >>> FRAC;
        zi = z >>> FRAC;
        fx = x & (ONE - 1);
        fz = z & (ONE - 1);
        h0 = grid_shadow[zi * SIDE + xi];
        h1 = grid_shadow[(zi + 1) * SIDE + xi];
        h2 = grid_shadow[zi * SIDE + xi + 1];
        h3 = grid_shadow[(zi + 1) * SIDE + xi + 1];
        // Pick the triangle on either side of the cell diagonal
        if (fx + fz < ONE)
            acc = h0 * ONE + (h1 - h0) * fz + (h2 - h0) * fx;
        else
            acc = h3 * ONE + (h1 - h3) * (ONE - fx) + (h2 - h3) * (ONE - fz);
        if (acc < 0) acc = 0;
        if (acc > HQ_MAX) acc = HQ_MAX;
        res.is_land   = 1'b1;
        res.height_q8 = acc[HQ_W-1:0];
        return res;
    endfunction

    // Offer one item, wait for acceptance, then update the shadow and expectations
    task automatic send_item(input logic req, input logic [VIDX_W-1:0] vidx,
                             input logic [HBYTE_W-1:0] hb,
                             input logic signed [POS_W-1:0] px,
                             input logic signed [POS_W-1:0] pz);
        logic [S_TDATA_W-1:0] word;
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word = '0;
        word[VIDX_LSB  +: VIDX_W]  = vidx;
        word[HBYTE_LSB +: HBYTE_W] = hb;
        word[POSX_LSB  +: POS_W]   = px;
        word[POSZ_LSB  +: POS_W]   = pz;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= req;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        items_counted++;
        if (req == REQ_QUERY) begin
            pending_heights = {pending_heights, predict_height(px, pz)};
        end else if (vidx < CELLS) begin
            grid_shadow[vidx]    = hb;
            vertex_written[vidx] = 1'b1;
        end
    endtask

    task automatic load_vertex(input int idx, input int hb);
        send_item(REQ_LOAD, VIDX_W'(idx), HBYTE_W'(hb), POS_W'($urandom()),
                  POS_W'($urandom()));
    endtask

    task automatic query_at(input int px, input int pz);
        send_item(REQ_QUERY, VIDX_W'($urandom()), HBYTE_W'($urandom()), POS_W'(px),
                  POS_W'(pz));
    endtask

    // Load any corner of the cell that was never written
    task automatic prepare_cell(input int xi, input int zi);
        int corner [4];
        bit added;
        corner[0] = zi * SIDE + xi;
        corner[1] = zi * SIDE + xi + 1;
        corner[2] = (zi + 1) * SIDE + xi;
        corner[3] = (zi + 1) * SIDE + xi + 1;
        added = 1'b0;
        foreach (corner[k]) begin
            if (!vertex_written[corner[k]]) begin
                load_vertex(corner[k], $urandom());
                added = 1'b1;
            end
        end
        if (added) ready_cells = {ready_cells, zi * TILES + xi};
    endtask

    function automatic int pick_frac();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return ONE - 1;
        return $urandom_range(0, ONE - 1);
    endfunction

    // Hold the sender until every expected result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_heights.size() != 0) @(posedge i_clk);
    endtask

    // Corners of the first and last cell, both triangles and the diagonal
    task automatic test_grid_corners();
        load_vertex(0, 0);
        load_vertex(1, 255);
        load_vertex(SIDE, 255);
        load_vertex(SIDE + 1, 0);
        load_vertex((SIDE - 2) * SIDE + SIDE - 2, 17);
        load_vertex((SIDE - 2) * SIDE + SIDE - 1, 200);
        load_vertex((SIDE - 1) * SIDE + SIDE - 2, 90);
        load_vertex(CELLS - 1, 255);
        ready_cells = {ready_cells, 0};
        ready_cells = {ready_cells, (TILES - 1) * TILES + TILES - 1};
        query_at(0, 0);
        query_at(ONE - 1, 0);
        query_at(0, ONE - 1);
        query_at(ONE / 2, ONE / 2 - 1);
        query_at(ONE / 2, ONE / 2);
        query_at(ONE - 1, ONE - 1);
        query_at(TILES * ONE - 1, TILES * ONE - 1);
        query_at((TILES - 1) * ONE, (TILES - 1) * ONE);
        query_at((TILES - 1) * ONE + 3, TILES * ONE - 1);
    endtask

    // Positions just and far outside the grid on each axis
    task automatic test_off_grid();
        query_at(-1, 0);
        query_at(0, -1);
        query_at(TILES * ONE, 0);
        query_at(0, TILES * ONE);
        query_at(-131072, -131072);
        query_at(131071, 131071);
        query_at(-131072, 131071);
    endtask

    // Loads past the last vertex must leave the grid untouched
    task automatic test_ignored_loads();
        load_vertex(CELLS, 'hA5);
        load_vertex((1 << VIDX_W) - 1, 'h5A);
        query_at(0, 0);
        query_at(TILES * ONE - 1, TILES * ONE - 1);
    endtask

    // Receiver holds off while queries keep coming, so the input stalls
    task automatic test_output_backpressure();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        prepare_cell(0, 1);
        rx_hold_cycles = 200;
        repeat (24) query_at(pick_frac(), ONE + pick_frac());
        wait_drained();
    endtask

    // Random loads and queries under changing idle patterns
    task automatic test_random_traffic();
        int stop_at, r, cell_id, xi, zi, since_mode, since_drain;
        logic signed [POS_W-1:0] px, pz;
        stop_at = items_counted + RAND_ITEMS;
        since_mode = 0;
        since_drain = 0;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        while (items_counted < stop_at) begin
            if (since_mode >= 150) begin
                since_mode = 0;
                tx_gaps = ($urandom_range(0, 3) != 0);
                rx_gaps = ($urandom_range(0, 3) != 0);
            end
            if (since_drain >= 500) begin
                since_drain = 0;
                wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // noise: load aimed past the grid
                load_vertex($urandom_range(CELLS, (1 << VIDX_W) - 1), $urandom());
            end else if (r < 18) begin
                px = POS_W'($urandom());
                pz = POS_W'($urandom());
                if (px >= 0 && px < TILES * ONE && pz >= 0 && pz < TILES * ONE)
                    px = POS_W'(px + TILES * ONE);
                query_at(px, pz);
            end else if (r < 28) begin
                load_vertex($urandom_range(0, CELLS - 1), $urandom());
            end else begin
                if (ready_cells.size() != 0 && $urandom_range(0, 1) == 0) begin
                    cell_id = ready_cells[$urandom_range(0, ready_cells.size() - 1)];
                    xi = cell_id % TILES;
                    zi = cell_id / TILES;
                end else begin
                    xi = ($urandom_range(0, 9) == 0) ? (TILES - 1) * $urandom_range(0, 1)
                                                     : $urandom_range(0, TILES - 1);
                    zi = ($urandom_range(0, 9) == 0) ? (TILES - 1) * $urandom_range(0, 1)
                                                     : $urandom_range(0, TILES - 1);
                    prepare_cell(xi, zi);
                end
                query_at(xi * ONE + pick_frac(), zi * ONE + pick_frac());
            end
            since_mode++;
            since_drain++;
        end
    endtask

    // Receiver ready: optional long hold, else random stalls or always ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (rx_hold_cycles > 0) begin
            rx_hold_cycles = rx_hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left = rx_stall_left - 1;
            m_tready <= 1'b0;
        end else if (rx_gaps && $urandom_range(0, 2) == 0) begin
            rx_stall_left = pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            if (pending_heights.size() == 0) begin
                $display("%0t: result with none expected: is_land %0d height %0d",
                         $time, o_m_axis_tuser[0], o_m_axis_tdata);
                mismatch_count++;
            end else begin
                next_height = pending_heights.pop_front();
                if (o_m_axis_tuser[0] !== next_height.is_land) begin
                    $display("%0t: is_land expected %0d, actual %0d",
                             $time, next_height.is_land, o_m_axis_tuser[0]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata !== next_height.height_q8) begin
                    $display("%0t: height_q8 expected %0d, actual %0d",
                             $time, next_height.height_q8, o_m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_heights.size());
            $display("heightmap_triangle_height_query_top: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_LOAD;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        test_grid_corners();
        test_off_grid();
        test_ignored_loads();
        test_output_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("heightmap_triangle_height_query_top: match");
        else
            $display("heightmap_triangle_height_query_top: mismatch");
        $finish;
    end

endmodule
